### rtl/hwsf_pkg.sv
`timescale 1ns / 1ps
package hwsf_pkg;

    localparam int OPW = 35;            // shared unit operand width
    localparam int PRW = 70;            // shared unit result width
    localparam int MUL_STEPS = 35;
    localparam int DIV_STEPS = 48;

    localparam logic [16:0] GAIN_ONE = 17'd65536;
    localparam logic [62:0] SSE_MAX = {63{1'b1}};
    localparam logic [32:0] SQ_LIMIT = 33'd3037000499;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [2:0] REG_ALPHA = 3'd0;
    localparam logic [2:0] REG_BETA = 3'd1;
    localparam logic [2:0] REG_GAMMA = 3'd2;
    localparam logic [2:0] REG_MODE = 3'd3;
    localparam logic [2:0] REG_SLEN = 3'd4;
    localparam logic [2:0] REG_ITREND = 3'd5;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'(S32_MAX))
            r = S32_MAX;
        else if (v < 72'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [16:0] clamp_gain(input logic [16:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

### rtl/hwsf_if.sv
`timescale 1ns / 1ps
interface hwsf_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] sample;
    logic series_start;
    modport source (output valid, output sample, output series_start, input ready);
    modport sink (input valid, input sample, input series_start, output ready);
endinterface

interface hwsf_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] level_out;
    logic signed [31:0] trend_out;
    logic signed [31:0] forecast_out;
    logic [62:0] sse_out;
    logic ready_res;
    logic div_fault;
    modport source (output valid, output level_out, output trend_out, output forecast_out,
                    output sse_out, output ready_res, output div_fault, input ready);
    modport sink (input valid, input level_out, input trend_out, input forecast_out,
                  input sse_out, input ready_res, input div_fault, output ready);
endinterface

interface hwsf_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/hwsf_mdu.sv
`timescale 1ns / 1ps
module hwsf_mdu (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic op_div,
    input  logic signed [hwsf_pkg::OPW-1:0] a,
    input  logic signed [hwsf_pkg::OPW-1:0] b,
    output logic done,
    output logic signed [hwsf_pkg::PRW-1:0] result
);
    import hwsf_pkg::*;

    logic run_reg, fin_reg, done_reg, div_reg, neg_reg;
    logic [5:0] cnt_reg;
    logic [PRW-1:0] mcand_reg, acc_reg;
    logic [OPW-1:0] mplier_reg;
    logic [47:0] dvd_reg, quo_reg;
    logic [31:0] den_reg, rem_reg;
    logic signed [PRW-1:0] result_reg;

    logic [OPW-1:0] a_mag, b_mag;
    logic [32:0] rem_sh;
    logic [33:0] trial;
    logic last;
    logic [PRW-1:0] mag;

    always_comb
    begin
        a_mag = a[OPW-1] ? (~a + OPW'(1)) : a;
        b_mag = b[OPW-1] ? (~b + OPW'(1)) : b;
        rem_sh = {rem_reg, dvd_reg[47]};
        trial = {1'b0, rem_sh} - {2'b00, den_reg};
        last = div_reg ? (cnt_reg == 6'(DIV_STEPS - 1)) : (cnt_reg == 6'(MUL_STEPS - 1));
        mag = div_reg ? {{(PRW-48){1'b0}}, quo_reg} : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (last)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= op_div;
            neg_reg <= a[OPW-1] ^ b[OPW-1];
            mcand_reg <= PRW'(a_mag);
            mplier_reg <= b_mag;
            acc_reg <= '0;
            dvd_reg <= {a_mag[31:0], 16'd0};
            den_reg <= b_mag[31:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            if (div_reg)
            begin
                // restoring division, one quotient bit per cycle
                dvd_reg <= {dvd_reg[46:0], 1'b0};
                if (!trial[33])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
            end
            else
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[PRW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[OPW-1:1]};
            end
        end
        if (fin_reg)
            result_reg <= neg_reg ? $signed(~mag + PRW'(1)) : $signed(mag);
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

### rtl/holt_winters_smoothing_filter.sv
`timescale 1ns / 1ps
// Holt-Winters smoothing filter, Q16.16 samples, Q1.16 gains.
// smp: one sample per transfer with a series_start mark. res: one result per
// sample (level, trend, forecast, error sum, ready and division fault flags).
// cfg: register writes by index, always ready; write only while idle.
// Each sample runs through the sequencer before the next can transfer: every
// product and quotient runs through one shift-add multiply / restoring divide
// unit, two to seven such operations per sample. A sample that starts a
// series goes straight to the result stage. smp.ready is high only while the
// sequencer is idle.
// The result sits in an output register; a new sample is taken while it
// waits, but that sample's result is held back until the old one transfers.
// Reset restores the register defaults, clears level, trend, error sum and
// counters and marks the whole season ring neutral (multiplicative 1.0).
// A series start marks the ring neutral for the current mode.
module holt_winters_smoothing_filter #(
    parameter int MAX_PERIOD = 64,
    parameter int MIN_SAMPLES = 4
) (
    input logic clk,
    input logic rst_n,
    hwsf_in_if.sink smp,
    hwsf_out_if.source res,
    hwsf_cfg_if.sink cfg
);
    import hwsf_pkg::*;

    localparam int PW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int LENW = $clog2(MAX_PERIOD + 1);
    localparam int CW = ((LENW > 7) ? LENW : 7) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_FC   = 4'd2;
    localparam logic [3:0] S_FCM  = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_OBS  = 4'd5;
    localparam logic [3:0] S_ODIV = 4'd6;
    localparam logic [3:0] S_LVG  = 4'd7;
    localparam logic [3:0] S_LVL  = 4'd8;
    localparam logic [3:0] S_TRG  = 4'd9;
    localparam logic [3:0] S_TRD  = 4'd10;
    localparam logic [3:0] S_SGO  = 4'd11;
    localparam logic [3:0] S_SDIV = 4'd12;
    localparam logic [3:0] S_SMG  = 4'd13;
    localparam logic [3:0] S_SEAS = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

    logic [3:0] state_reg;

    logic [16:0] alpha_reg, beta_reg, gamma_reg;
    logic mode_reg;
    logic [6:0] slen_reg;
    logic signed [31:0] itrend_reg;

    logic signed [31:0] y_reg, level_reg, trend_reg, old_level_reg, st_reg, fc_reg;
    logic signed [31:0] fill_reg;
    logic signed [32:0] base_reg, obs_reg, so_reg;
    logic [62:0] sse_reg;
    logic start_reg, fault_reg;
    logic [2:0] cnt_reg;
    logic [PW-1:0] pos_reg;
    logic [MAX_PERIOD-1:0] valid_reg;

    logic [31:0] ring_mem [MAX_PERIOD];
    logic signed [31:0] ring_rd_reg;
    logic ring_vld_reg;

    logic out_valid_reg;
    logic signed [31:0] o_level_reg, o_trend_reg, o_fc_reg;
    logic [62:0] o_sse_reg;
    logic o_rdy_reg, o_fault_reg;

    logic go_reg, op_div_reg;
    logic signed [OPW-1:0] op_a_reg, op_b_reg;
    logic mdu_done;
    logic signed [PRW-1:0] mdu_res;

    logic [16:0] ga, gb, gg;
    logic [CW-1:0] len_c, pos_ext, pos_inc;
    logic [PW-1:0] pos_fix, pos_next;
    logic signed [31:0] fc_add, fc_mul, blend_v, dq_v, fc_v;
    logic signed [32:0] res_v;
    logic [32:0] res_mag;
    logic [62:0] sq_v;
    logic [63:0] sse_sum;
    logic signed [31:0] st_c, nl_v;
    logic out_free;

    hwsf_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (go_reg),
        .op_div (op_div_reg),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .done   (mdu_done),
        .result (mdu_res)
    );

    always_comb
    begin
        ga = clamp_gain(alpha_reg);
        gb = clamp_gain(beta_reg);
        gg = clamp_gain(gamma_reg);
        if (slen_reg == 7'd0)
            len_c = CW'(1);
        else if (CW'(slen_reg) > CW'(MAX_PERIOD))
            len_c = CW'(MAX_PERIOD);
        else
            len_c = CW'(slen_reg);
        pos_ext = CW'(pos_reg);
        pos_fix = (pos_ext >= len_c) ? '0 : pos_reg;
        pos_inc = pos_ext + CW'(1);
        pos_next = (pos_inc >= len_c) ? '0 : pos_inc[PW-1:0];

        if (gg != 17'd0)
            st_c = ring_vld_reg ? ring_rd_reg : fill_reg;
        else
            st_c = mode_reg ? Q_ONE : 32'sd0;

        fc_add = sat32(72'(base_reg) + 72'(st_reg));
        fc_mul = sat32(72'(mdu_res >>> 16));
        // forecast is held in fc_reg once the square is under way
        fc_v = (state_reg == S_FCM) ? fc_mul : ((state_reg == S_SQ) ? fc_reg : fc_add);
        res_v = 33'(y_reg) - 33'(fc_v);
        res_mag = res_v[32] ? (~res_v + 33'd1) : res_v;

        sq_v = (res_mag > SQ_LIMIT) ? SSE_MAX : mdu_res[62:0];
        sse_sum = {1'b0, sse_reg} + {1'b0, sq_v};

        // g*x + (1-g)*y == g*(x-y) + y, floored to Q16.16
        case (state_reg)
            S_LVL: blend_v = sat32((72'(mdu_res) + (72'(base_reg) <<< 16)) >>> 16);
            S_TRD: blend_v = sat32((72'(mdu_res) + (72'(trend_reg) <<< 16)) >>> 16);
            default: blend_v = sat32((72'(mdu_res) + (72'(st_reg) <<< 16)) >>> 16);
        endcase
        nl_v = blend_v;
        dq_v = sat32(72'(mdu_res));
        out_free = !out_valid_reg || res.ready;
    end

    assign cfg.ready = 1'b1;
    assign smp.ready = (state_reg == S_IDLE);

    assign res.valid = out_valid_reg;
    assign res.level_out = o_level_reg;
    assign res.trend_out = o_trend_reg;
    assign res.forecast_out = o_fc_reg;
    assign res.sse_out = o_sse_reg;
    assign res.ready_res = o_rdy_reg;
    assign res.div_fault = o_fault_reg;

    always_ff @(posedge clk)
    begin
        ring_rd_reg <= ring_mem[pos_fix];
        if (state_reg == S_SEAS && mdu_done)
            ring_mem[pos_reg] <= blend_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 17'd19661;
            beta_reg <= 17'd3277;
            gamma_reg <= 17'd0;
            mode_reg <= 1'b1;
            slen_reg <= 7'd1;
            itrend_reg <= '0;
            state_reg <= S_IDLE;
            level_reg <= '0;
            trend_reg <= '0;
            sse_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
            valid_reg <= '0;
            fill_reg <= Q_ONE;
            ring_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            ring_vld_reg <= valid_reg[pos_fix];
            if (out_valid_reg && res.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ALPHA: alpha_reg <= cfg.data[16:0];
                    REG_BETA: beta_reg <= cfg.data[16:0];
                    REG_GAMMA: gamma_reg <= cfg.data[16:0];
                    REG_MODE: mode_reg <= cfg.data[0];
                    REG_SLEN: slen_reg <= cfg.data[6:0];
                    REG_ITREND: itrend_reg <= cfg.data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (smp.valid)
                    begin
                        y_reg <= smp.sample;
                        start_reg <= smp.series_start;
                        fault_reg <= 1'b0;
                        if (smp.series_start)
                        begin
                            level_reg <= smp.sample;
                            trend_reg <= (gb != 17'd0) ? itrend_reg : 32'sd0;
                            valid_reg <= '0;
                            fill_reg <= mode_reg ? Q_ONE : 32'sd0;
                            pos_reg <= '0;
                            sse_reg <= '0;
                            cnt_reg <= 3'd1;
                            fc_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            pos_reg <= pos_fix;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    st_reg <= st_c;
                    old_level_reg <= level_reg;
                    base_reg <= 33'(level_reg) + 33'(trend_reg);
                    state_reg <= S_FC;
                end
                S_FC:
                begin
                    go_reg <= 1'b1;
                    op_div_reg <= 1'b0;
                    if (mode_reg)
                    begin
                        op_a_reg <= OPW'(sat32(72'(base_reg)));
                        op_b_reg <= OPW'(st_reg);
                        state_reg <= S_FCM;
                    end
                    else
                    begin
                        fc_reg <= fc_add;
                        op_a_reg <= OPW'(res_v);
                        op_b_reg <= OPW'(res_v);
                        state_reg <= S_SQ;
                    end
                end
                S_FCM:
                begin
                    if (mdu_done)
                    begin
                        fc_reg <= fc_mul;
                        go_reg <= 1'b1;
                        op_div_reg <= 1'b0;
                        op_a_reg <= OPW'(res_v);
                        op_b_reg <= OPW'(res_v);
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (mdu_done)
                    begin
                        sse_reg <= (sse_sum > {1'b0, SSE_MAX}) ? SSE_MAX : sse_sum[62:0];
                        state_reg <= S_OBS;
                    end
                end
                S_OBS:
                begin
                    if (mode_reg && st_reg != 32'sd0)
                    begin
                        go_reg <= 1'b1;
                        op_div_reg <= 1'b1;
                        op_a_reg <= OPW'(y_reg);
                        op_b_reg <= OPW'(st_reg);
                        state_reg <= S_ODIV;
                    end
                    else
                    begin
                        if (mode_reg)
                        begin
                            fault_reg <= 1'b1;
                            obs_reg <= 33'(y_reg[31] ? S32_MIN : S32_MAX);
                        end
                        else
                            obs_reg <= 33'(y_reg) - 33'(st_reg);
                        state_reg <= S_LVG;
                    end
                end
                S_ODIV:
                begin
                    if (mdu_done)
                    begin
                        obs_reg <= 33'(dq_v);
                        state_reg <= S_LVG;
                    end
                end
                S_LVG:
                begin
                    go_reg <= 1'b1;
                    op_div_reg <= 1'b0;
                    op_a_reg <= OPW'(ga);
                    op_b_reg <= OPW'(obs_reg) - OPW'(base_reg);
                    state_reg <= S_LVL;
                end
                S_LVL:
                begin
                    if (mdu_done)
                    begin
                        level_reg <= nl_v;
                        state_reg <= S_TRG;
                    end
                end
                S_TRG:
                begin
                    if (gb != 17'd0)
                    begin
                        go_reg <= 1'b1;
                        op_div_reg <= 1'b0;
                        op_a_reg <= OPW'(gb);
                        op_b_reg <= OPW'(level_reg) - OPW'(old_level_reg) - OPW'(trend_reg);
                        state_reg <= S_TRD;
                    end
                    else
                    begin
                        trend_reg <= '0;
                        state_reg <= S_SGO;
                    end
                end
                S_TRD:
                begin
                    if (mdu_done)
                    begin
                        trend_reg <= blend_v;
                        state_reg <= S_SGO;
                    end
                end
                S_SGO:
                begin
                    if (gg == 17'd0)
                        state_reg <= S_DONE;
                    else if (mode_reg && level_reg != 32'sd0)
                    begin
                        go_reg <= 1'b1;
                        op_div_reg <= 1'b1;
                        op_a_reg <= OPW'(y_reg);
                        op_b_reg <= OPW'(level_reg);
                        state_reg <= S_SDIV;
                    end
                    else
                    begin
                        if (mode_reg)
                        begin
                            fault_reg <= 1'b1;
                            so_reg <= 33'(y_reg[31] ? S32_MIN : S32_MAX);
                        end
                        else
                            so_reg <= 33'(y_reg) - 33'(level_reg);
                        state_reg <= S_SMG;
                    end
                end
                S_SDIV:
                begin
                    if (mdu_done)
                    begin
                        so_reg <= 33'(dq_v);
                        state_reg <= S_SMG;
                    end
                end
                S_SMG:
                begin
                    go_reg <= 1'b1;
                    op_div_reg <= 1'b0;
                    op_a_reg <= OPW'(gg);
                    op_b_reg <= OPW'(so_reg) - OPW'(st_reg);
                    state_reg <= S_SEAS;
                end
                S_SEAS:
                begin
                    if (mdu_done)
                    begin
                        valid_reg[pos_reg] <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_level_reg <= level_reg;
                        o_trend_reg <= trend_reg;
                        o_fc_reg <= fc_reg;
                        o_sse_reg <= sse_reg;
                        o_fault_reg <= fault_reg;
                        if (start_reg)
                            o_rdy_reg <= (cnt_reg >= 3'(MIN_SAMPLES));
                        else
                        begin
                            pos_reg <= pos_next;
                            if (cnt_reg != 3'd7)
                                cnt_reg <= cnt_reg + 3'd1;
                            o_rdy_reg <= ((cnt_reg == 3'd7 ? cnt_reg : cnt_reg + 3'd1)
                                          >= 3'(MIN_SAMPLES));
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/hwsf_checker.sv
`timescale 1ns / 1ps
module hwsf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic signed [31:0] level_out,
    input logic [62:0] sse_out
);

    // one sample in flight: after a transfer the input side closes
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready while a sample is in work");

    // a fresh result means the sequencer has gone back to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded but input side not open");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level_out) && $stable(sse_out))
        else $error("stalled result changed");

endmodule

bind holt_winters_smoothing_filter hwsf_checker u_hwsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (smp.valid),
    .in_ready  (smp.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .level_out (res.level_out),
    .sse_out   (res.sse_out)
);
